### rtl/core/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg - shared types and constants for the reconnect backoff controller
// Connection states, register indexes, operation codes and the structs that
// travel between the configuration block, the step logic and the top level.
// ----------------------------------------------------------------------------
package rbc_pkg;

  // Field widths
  localparam int unsigned DELAY_W = 31;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned IDX_W   = 2;

  // Delay constants, in ms
  localparam logic [DELAY_W-1:0] FLOOR_MS      = 31'd100;
  localparam logic [DELAY_W-1:0] RST_MIN_MS    = 31'd1000;
  localparam logic [DELAY_W-1:0] RST_MAX_MS    = 31'd10000;
  localparam logic [DELAY_W-1:0] RST_DELAY_MS  = 31'd1000;

  // Supervisor states, encoded as reported on conn_state
  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_TRYING    = 2'd1,
    ST_BACKOFF   = 2'd2,
    ST_CONNECTED = 2'd3
  } conn_state_e;

  // Input operation codes
  typedef enum logic {
    OP_START = 1'b0,
    OP_POLL  = 1'b1
  } op_e;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_RETRY_MIN = 2'd0;
  localparam logic [IDX_W-1:0] CFG_RETRY_MAX = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HOST      = 2'd2;

  // Clamped limits and host flag from the configuration block
  typedef struct packed {
    logic [DELAY_W-1:0] min_ms;
    logic [DELAY_W-1:0] max_ms;
    logic               host;
  } limits_t;

  // Supervisor state carried from beat to beat
  typedef struct packed {
    conn_state_e        conn;
    logic [DELAY_W-1:0] delay;
    logic [TIME_W-1:0]  last_ms;
  } sup_state_t;

  // One input beat
  typedef struct packed {
    op_e               op;
    logic [TIME_W-1:0] now_ms;
    logic              net_ready;
    logic              link_up;
    logic              connect_ok;
  } beat_in_t;

  // One result beat
  typedef struct packed {
    conn_state_e        conn;
    logic               attempt;
    logic               resub;
    logic               changed;
    logic [DELAY_W-1:0] delay;
  } beat_out_t;

endpackage

### rtl/core/reconnect_backoff_controller_core.sv
// ----------------------------------------------------------------------------
// reconnect_backoff_controller_core - connection supervisor with backoff
// Takes one beat per cycle while the output is not stalled and returns one
// result beat for each: the beat is captured in an input register, the step
// logic updates the supervisor state (idle, trying, backoff, connected,
// delay, last attempt time) and fills the result register as the beat moves
// on, once that register is free or draining. Throughput is one beat per
// cycle while the output is not stalled; while a result waits the
// input register can still take one beat, then the input stalls.
// Configuration writes take effect on the
// next edge and are meant for when no beat is in flight. No clearing pass
// after reset.
// ----------------------------------------------------------------------------
module reconnect_backoff_controller_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [rbc_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [rbc_pkg::DELAY_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [rbc_pkg::TIME_W-1:0]  now_ms_i,
  input  logic                        net_ready_i,
  input  logic                        link_up_i,
  input  logic                        connect_ok_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  conn_state_o,
  output logic                        attempt_made_o,
  output logic                        resubscribe_o,
  output logic                        state_changed_o,
  output logic [rbc_pkg::DELAY_W-1:0] retry_delay_ms_o
);
  import rbc_pkg::*;

  limits_t    limits;
  beat_in_t   beat_q, beat_d;
  logic       s1_valid_q;
  logic       s1_fire;
  logic       in_fire;
  sup_state_t st_q, st_nxt;
  beat_out_t  res_q, res_nxt;
  logic       out_valid_q;

  rbc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .limits_o   (limits)
  );

  rbc_step u_step (
    .beat_i  (beat_q),
    .cur_i   (st_q),
    .limits_i(limits),
    .nxt_o   (st_nxt),
    .res_o   (res_nxt)
  );

  // Handshake: input stage moves when the result register is free or drains
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign beat_d.op         = op_e'(op_i);
  assign beat_d.now_ms     = now_ms_i;
  assign beat_d.net_ready  = net_ready_i;
  assign beat_d.link_up    = link_up_i;
  assign beat_d.connect_ok = connect_ok_i;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      beat_q <= beat_d;
    end
  end

  // Supervisor state, updated as a beat moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.conn    <= ST_IDLE;
      st_q.delay   <= RST_DELAY_MS;
      st_q.last_ms <= '0;
    end else if (s1_fire) begin
      st_q <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_nxt;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign conn_state_o     = res_q.conn;
  assign attempt_made_o   = res_q.attempt;
  assign resubscribe_o    = res_q.resub;
  assign state_changed_o  = res_q.changed;
  assign retry_delay_ms_o = res_q.delay;

  // Checks
  a_delay_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.delay >= FLOOR_MS)
    else $error("retry delay below floor");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(st_q))
    else $error("supervisor state moved without a beat");

  a_attempt_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && attempt_made_o |->
      (conn_state_o == ST_CONNECTED || conn_state_o == ST_BACKOFF))
    else $error("attempt reported outside connected or backoff");

  a_resub_attempt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && resubscribe_o |-> attempt_made_o && conn_state_o == ST_CONNECTED)
    else $error("resubscribe without a successful attempt");

  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_o && conn_state_o == st_q.conn && retry_delay_ms_o == st_q.delay)
    else $error("result beat disagrees with supervisor state");

endmodule

### rtl/core/rbc_cfg.sv
// ----------------------------------------------------------------------------
// rbc_cfg - configuration registers and delay limits
// Holds the retry window registers and the host flag, and derives the
// effective minimum (at least the floor) and maximum (at least the minimum).
// ----------------------------------------------------------------------------
module rbc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rbc_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [rbc_pkg::DELAY_W-1:0] cfg_wdata_i,
  output rbc_pkg::limits_t            limits_o
);
  import rbc_pkg::*;

  logic [DELAY_W-1:0] min_q, min_d;
  logic [DELAY_W-1:0] max_q, max_d;
  logic               host_q, host_d;
  logic [DELAY_W-1:0] eff_min;

  // Register write decode; unknown indexes are ignored
  always_comb begin
    min_d  = min_q;
    max_d  = max_q;
    host_d = host_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RETRY_MIN: min_d  = cfg_wdata_i;
        CFG_RETRY_MAX: max_d  = cfg_wdata_i;
        CFG_HOST:      host_d = cfg_wdata_i[0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= RST_MIN_MS;
      max_q  <= RST_MAX_MS;
      host_q <= 1'b0;
    end else begin
      min_q  <= min_d;
      max_q  <= max_d;
      host_q <= host_d;
    end
  end

  // Clamp: minimum raised to the floor, maximum raised to the minimum
  assign eff_min         = (min_q < FLOOR_MS) ? FLOOR_MS : min_q;
  assign limits_o.min_ms = eff_min;
  assign limits_o.max_ms = (max_q < eff_min) ? eff_min : max_q;
  assign limits_o.host   = host_q;

endmodule

### rtl/core/rbc_step.sv
// ----------------------------------------------------------------------------
// rbc_step - supervisor step logic
// Computes the next supervisor state and the result beat for one input beat
// from the current state and the configured limits.
// ----------------------------------------------------------------------------
module rbc_step (
  input  rbc_pkg::beat_in_t   beat_i,
  input  rbc_pkg::sup_state_t cur_i,
  input  rbc_pkg::limits_t    limits_i,
  output rbc_pkg::sup_state_t nxt_o,
  output rbc_pkg::beat_out_t  res_o
);
  import rbc_pkg::*;

  logic [TIME_W-1:0]  elapsed;
  logic               due;
  logic [TIME_W-1:0]  dbl;
  logic [DELAY_W-1:0] capped;
  logic               attempt;
  logic               resub;

  // Wrapped elapsed time against the delay in force
  assign elapsed = beat_i.now_ms - cur_i.last_ms;
  assign due     = elapsed >= {1'b0, cur_i.delay};

  // Doubled delay, limited to the maximum; fits 31 bits when below it
  assign dbl    = {cur_i.delay, 1'b0};
  assign capped = (dbl < {1'b0, limits_i.max_ms}) ? dbl[DELAY_W-1:0] : limits_i.max_ms;

  // Next state
  always_comb begin
    nxt_o = cur_i;
    if (beat_i.op == OP_START) begin
      nxt_o.delay = limits_i.min_ms;
      nxt_o.conn  = limits_i.host ? ST_TRYING : ST_IDLE;
    end else begin
      case (cur_i.conn)
        ST_TRYING, ST_BACKOFF: begin
          if (!limits_i.host) begin
            nxt_o.conn = ST_IDLE;
          end else if (due) begin
            nxt_o.last_ms = beat_i.now_ms;
            if (!beat_i.net_ready) begin
              nxt_o.conn = ST_TRYING;
            end else if (beat_i.connect_ok) begin
              nxt_o.conn  = ST_CONNECTED;
              nxt_o.delay = limits_i.min_ms;
            end else begin
              nxt_o.conn  = ST_BACKOFF;
              nxt_o.delay = capped;
            end
          end
        end
        ST_CONNECTED: begin
          if (!beat_i.link_up) begin
            nxt_o.conn  = ST_TRYING;
            nxt_o.delay = limits_i.min_ms;
          end
        end
        default: ;
      endcase
    end
  end

  // Attempt and resubscribe flags
  always_comb begin
    attempt = 1'b0;
    resub   = 1'b0;
    if (beat_i.op == OP_POLL && limits_i.host && due && beat_i.net_ready) begin
      case (cur_i.conn)
        ST_TRYING, ST_BACKOFF: begin
          attempt = 1'b1;
          resub   = beat_i.connect_ok;
        end
        default: ;
      endcase
    end
  end

  // Result beat
  assign res_o.conn    = nxt_o.conn;
  assign res_o.attempt = attempt;
  assign res_o.resub   = resub;
  assign res_o.changed = nxt_o.conn != cur_i.conn;
  assign res_o.delay   = nxt_o.delay;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the reconnect backoff controller core
// Drives start and poll beats through the valid/ready input channel.
// Random gaps are applied on both channels. A behavioral supervisor in this
// file predicts every result beat. A checker process compares each accepted
// result, field by field, with the oldest prediction. Directed cases come
// first. Random phases follow under a range of retry limits and host
// settings.
// ----------------------------------------------------------------------------
module tb_top;
  import rbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [DELAY_W-1:0] DELAY_TOP = 31'h7FFF_FFFF;

  // DUT connections
  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [IDX_W-1:0]    cfg_idx     = '0;
  logic [DELAY_W-1:0]  cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic                beat_op     = 1'b0;
  logic [TIME_W-1:0]   beat_now    = '0;
  logic                beat_net    = 1'b0;
  logic                beat_link   = 1'b0;
  logic                beat_ok     = 1'b0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [1:0]          conn_state;
  logic                attempt_made;
  logic                resubscribe;
  logic                state_changed;
  logic [DELAY_W-1:0]  retry_delay_ms;

  // Testbench bookkeeping
  logic                gaps_on     = 1'b1;
  int unsigned         cycle_count = 0;
  int unsigned         err_count   = 0;
  beat_out_t           status_q[$];

  // Predicted supervisor state and register copies
  conn_state_e         sv_conn;
  logic [DELAY_W-1:0]  sv_delay;
  logic [TIME_W-1:0]   sv_last;
  logic [DELAY_W-1:0]  lim_min;
  logic [DELAY_W-1:0]  lim_max;
  logic                lim_host;

  reconnect_backoff_controller_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .op_i             (beat_op),
    .now_ms_i         (beat_now),
    .net_ready_i      (beat_net),
    .link_up_i        (beat_link),
    .connect_ok_i     (beat_ok),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .conn_state_o     (conn_state),
    .attempt_made_o   (attempt_made),
    .resubscribe_o    (resubscribe),
    .state_changed_o  (state_changed),
    .retry_delay_ms_o (retry_delay_ms)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side backpressure
  always @(posedge clk) begin
    out_ready <= !(gaps_on && ($urandom_range(99) < 8));
  end

  // Effective limits as the block derives them from the registers
  function automatic logic [DELAY_W-1:0] floor_min();
    return (lim_min < FLOOR_MS) ? FLOOR_MS : lim_min;
  endfunction

  function automatic logic [DELAY_W-1:0] ceil_max();
    logic [DELAY_W-1:0] lo;
    lo = floor_min();
    return (lim_max < lo) ? lo : lim_max;
  endfunction

  // Advance the predicted supervisor by one beat and queue its status
  task automatic supervise_step(input beat_in_t b);
    conn_state_e        prev;
    beat_out_t          r;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  doubled;
    prev = sv_conn;
    r    = '0;
    if (b.op == OP_START) begin
      sv_delay = floor_min();
      sv_conn  = lim_host ? ST_TRYING : ST_IDLE;
    end else if (sv_conn == ST_TRYING || sv_conn == ST_BACKOFF) begin
      elapsed = b.now_ms - sv_last;
      if (!lim_host) begin
        sv_conn = ST_IDLE;
      end else if (elapsed >= {1'b0, sv_delay}) begin
        sv_last = b.now_ms;
        if (!b.net_ready) begin
          sv_conn = ST_TRYING;
        end else begin
          r.attempt = 1'b1;
          if (b.connect_ok) begin
            sv_conn  = ST_CONNECTED;
            sv_delay = floor_min();
            r.resub  = 1'b1;
          end else begin
            // doubled delay fits in 32 bits, clamp back to 31
            doubled  = {sv_delay, 1'b0};
            sv_conn  = ST_BACKOFF;
            sv_delay = (doubled < {1'b0, ceil_max()}) ? doubled[DELAY_W-1:0] : ceil_max();
          end
        end
      end
    end else if (sv_conn == ST_CONNECTED && !b.link_up) begin
      sv_conn  = ST_TRYING;
      sv_delay = floor_min();
    end
    r.conn    = sv_conn;
    r.changed = (sv_conn != prev);
    r.delay   = sv_delay;
    status_q.push_back(r);
  endtask

  // Result checker: sampled mid-cycle, beat taken at the next rising edge
  always @(negedge clk) begin
    beat_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        $error("result beat with no prediction pending");
        err_count++;
      end else begin
        want = status_q.pop_front();
        if (conn_state !== want.conn) begin
          $error("conn_state: expected %0d, actual %0d", want.conn, conn_state);
          err_count++;
        end
        if (attempt_made !== want.attempt) begin
          $error("attempt_made: expected %0d, actual %0d", want.attempt, attempt_made);
          err_count++;
        end
        if (resubscribe !== want.resub) begin
          $error("resubscribe: expected %0d, actual %0d", want.resub, resubscribe);
          err_count++;
        end
        if (state_changed !== want.changed) begin
          $error("state_changed: expected %0d, actual %0d", want.changed, state_changed);
          err_count++;
        end
        if (retry_delay_ms !== want.delay) begin
          $error("retry_delay_ms: expected %0d, actual %0d", want.delay, retry_delay_ms);
          err_count++;
        end
      end
    end
  end

  // Send one beat; returns at the edge that accepts it
  task automatic send_beat(input op_e op, input logic [TIME_W-1:0] now_ms,
                           input logic net, input logic link, input logic ok);
    beat_in_t b;
    b.op         = op;
    b.now_ms     = now_ms;
    b.net_ready  = net;
    b.link_up    = link;
    b.connect_ok = ok;
    while (gaps_on && ($urandom_range(99) < 8)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    beat_op   <= b.op;
    beat_now  <= b.now_ms;
    beat_net  <= b.net_ready;
    beat_link <= b.link_up;
    beat_ok   <= b.connect_ok;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    supervise_step(b);
  endtask

  // Poll shorthand
  task automatic poll(input logic [TIME_W-1:0] now_ms, input logic net,
                      input logic link, input logic ok);
    send_beat(OP_POLL, now_ms, net, link, ok);
  endtask

  // Let all outstanding results come back with the input channel quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers; only called with nothing in flight
  task automatic set_limits(input logic [DELAY_W-1:0] min_ms,
                            input logic [DELAY_W-1:0] max_ms, input logic host);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_RETRY_MIN;
    cfg_wdata <= min_ms;
    @(posedge clk);
    cfg_idx   <= CFG_RETRY_MAX;
    cfg_wdata <= max_ms;
    @(posedge clk);
    cfg_idx   <= CFG_HOST;
    cfg_wdata <= {{(DELAY_W-1){1'b0}}, host};
    @(posedge clk);
    cfg_we    <= 1'b0;
    lim_min  = min_ms;
    lim_max  = max_ms;
    lim_host = host;
  endtask

  // Reset defaults: host off, poll in idle and start both leave idle
  task automatic test_reset_state();
    poll(32'h0, 1'b1, 1'b1, 1'b1);
    send_beat(OP_START, 32'h0, 1'b1, 1'b1, 1'b1);
  endtask

  // Minimum raised to the floor, maximum raised to the minimum, then doubling
  task automatic test_backoff_ladder();
    drain();
    set_limits(31'd50, 31'd0, 1'b1);
    send_beat(OP_START, 32'd0, 1'b0, 1'b0, 1'b0);
    poll(32'd99, 1'b1, 1'b1, 1'b0);   // not elapsed yet
    poll(32'd100, 1'b0, 1'b1, 1'b1);  // network down: stamp only
    poll(32'd200, 1'b1, 1'b1, 1'b0);  // failed attempt, capped at max
    drain();
    set_limits(31'd100, DELAY_TOP, 1'b1);
    poll(32'd300, 1'b1, 1'b0, 1'b0);
    poll(32'd500, 1'b1, 1'b0, 1'b0);
    poll(32'd900, 1'b1, 1'b0, 1'b0);
  endtask

  // Success, session loss, host removal while connected, poll with no host
  task automatic test_connect_and_drop();
    poll(32'd1700, 1'b1, 1'b1, 1'b1);
    poll(32'd1800, 1'b1, 1'b1, 1'b0);
    drain();
    set_limits(31'd100, DELAY_TOP, 1'b0);
    poll(32'd1900, 1'b0, 1'b1, 1'b0); // host gone is ignored while connected
    poll(32'd2000, 1'b1, 1'b0, 1'b1); // session lost
    poll(32'd2100, 1'b1, 1'b1, 1'b1); // no host: back to idle
    send_beat(OP_START, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
  endtask

  // Largest delays, saturated doubling and time stamp wrap
  task automatic test_extremes();
    drain();
    set_limits(DELAY_TOP, DELAY_TOP, 1'b1);
    send_beat(OP_START, 32'h0, 1'b0, 1'b1, 1'b0);
    poll(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    poll(32'h7FFF_FFFD, 1'b1, 1'b1, 1'b1); // one short of the delay
    poll(32'h7FFF_FFFE, 1'b1, 1'b1, 1'b1); // exactly the delay
    drain();
    set_limits(31'd0, 31'd0, 1'b1);
    send_beat(OP_START, 32'h1234_5678, 1'b1, 1'b1, 1'b1);
    poll(32'hFFFF_FFF0, 1'b0, 1'b1, 1'b1);
    poll(32'h0000_0040, 1'b1, 1'b1, 1'b1); // wrapped, still short
    poll(32'h0000_0054, 1'b1, 1'b1, 1'b1); // wrapped, just elapsed
  endtask

  // One random beat; most follow the predicted timeline to reach deep states
  task automatic send_random_beat();
    op_e               op;
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] span;
    int unsigned       pick;
    if ($urandom_range(99) < 10) begin
      op = op_e'($urandom_range(1));
      send_beat(op, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
    end else begin
      op   = ($urandom_range(99) < 3) ? OP_START : OP_POLL;
      pick = $urandom_range(9);
      span = {sv_delay, 1'b0};
      if (pick < 4)      delta = {1'b0, sv_delay} + $urandom_range(2) - 1;
      else if (pick < 8) delta = $urandom_range(span, 0);
      else               delta = $urandom;
      send_beat(op, sv_last + delta, $urandom_range(99) < 85,
                $urandom_range(99) < 85, 1'($urandom_range(1)));
    end
  endtask

  // Random phases under a spread of register settings
  task automatic test_random();
    logic [DELAY_W-1:0] mins[10];
    logic [DELAY_W-1:0] maxs[10];
    logic               hosts[10];
    mins[0] = 31'd1000;  maxs[0] = 31'd10000;  hosts[0] = 1'b1;
    mins[1] = 31'd0;     maxs[1] = 31'd0;      hosts[1] = 1'b1;
    mins[2] = 31'd100;   maxs[2] = 31'd800;    hosts[2] = 1'b1;
    mins[3] = DELAY_W'($urandom_range(300));
    maxs[3] = DELAY_W'($urandom_range(3000));
    hosts[3] = 1'b1;
    mins[4] = DELAY_TOP; maxs[4] = DELAY_TOP;  hosts[4] = 1'b1;
    mins[5] = DELAY_W'($urandom);
    maxs[5] = DELAY_W'($urandom);
    hosts[5] = 1'($urandom_range(1));
    mins[6] = 31'd50;    maxs[6] = DELAY_TOP;  hosts[6] = 1'b1;
    mins[7] = 31'd500;   maxs[7] = 31'd200;    hosts[7] = 1'b1;
    mins[8] = 31'd300;   maxs[8] = 31'd200;    hosts[8] = 1'b0;
    mins[9] = DELAY_W'($urandom_range(2000));
    maxs[9] = DELAY_W'($urandom);
    hosts[9] = 1'b1;
    for (int p = 0; p < 10; p++) begin
      drain();
      gaps_on = (p != 2);  // one long stretch at full rate on both sides
      set_limits(mins[p], maxs[p], hosts[p]);
      send_beat(OP_START, $urandom, 1'b1, 1'b1, 1'b1);
      for (int i = 0; i < 99; i++) send_random_beat();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    sv_conn  = ST_IDLE;
    sv_delay = RST_DELAY_MS;
    sv_last  = '0;
    lim_min  = RST_MIN_MS;
    lim_max  = RST_MAX_MS;
    lim_host = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_backoff_ladder();
    test_connect_and_drop();
    test_extremes();
    test_random();

    drain();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
